// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("checker assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("checker assertion failed");

`endif

// ===== rtl/mlpe_pkg.sv =====
// ----------------------------------------------------------------------------
// mlpe_pkg
// Shared types and constants of the marker/length payload extractor.
// ----------------------------------------------------------------------------
package mlpe_pkg;

  localparam int unsigned MAX_PACKET_BYTES_DEF = 1024;
  localparam int unsigned LEN_W                = 17;
  localparam int unsigned WIN_W                = 11;
  localparam int unsigned PAYLOAD_OFFSET       = 9;
  localparam int unsigned DIGIT_COUNT          = 5;
  localparam int unsigned SIZE_TAG_BYTES       = 4;

  localparam logic [WIN_W-1:0] MARKER_WINDOW_RESET = 11'd300;
  localparam logic [39:0]      MARK_STONE          = 40'h73746F6E65;
  localparam logic [31:0]      MARK_SIZE           = 32'h73697A65;
  localparam logic [7:0]       CHAR_ZERO           = 8'h30;
  localparam logic [7:0]       CHAR_NINE           = 8'h39;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef struct packed {
    logic packet_done;
    logic marker_seen;
    logic size_seen;
  } scan_flags_t;

endpackage

// ===== rtl/mlpe_ram.sv =====
// ----------------------------------------------------------------------------
// mlpe_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mlpe_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/mlpe_scan.sv =====
// ----------------------------------------------------------------------------
// mlpe_scan
// Per-byte packet scanner: store write port, marker match, size tag match
// and decimal length parsing.
// ----------------------------------------------------------------------------
module mlpe_scan import mlpe_pkg::*; #(
  parameter int unsigned MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF,
  localparam int unsigned PW = $clog2(MAX_PACKET_BYTES + 1),
  localparam int unsigned AW = $clog2(MAX_PACKET_BYTES)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  logic [7:0]        data_byte_i,
  input  logic              eop_i,
  input  logic [WIN_W-1:0]  marker_window_i,
  output scan_flags_t       flags_o,
  output logic [PW-1:0]     size_pos_o,
  output logic [LEN_W-1:0]  length_o,
  output logic [PW-1:0]     write_pos_o,
  output logic              we_o,
  output logic [AW-1:0]     waddr_o
);

  localparam int unsigned CW = ((PW > LEN_W) ? PW : LEN_W) + 2;
  localparam logic [CW-1:0] MAX_C = CW'(MAX_PACKET_BYTES);

  logic [PW-1:0]    write_pos_q, write_pos_d;
  logic [39:0]      recent_q, recent_d;
  logic             marker_q, marker_d;
  logic             size_q, size_d;
  logic [PW-1:0]    size_pos_q, size_pos_d;
  logic [LEN_W-1:0] length_q, length_d;
  logic             done_q, done_d;
  logic             stopped_q, stopped_d;

  logic [CW-1:0]    pos_c;
  logic [CW-1:0]    sp_c;
  logic [39:0]      recent_new;
  logic             in_range;
  logic             is_digit;

  // A load after a finished packet starts from cleared state.
  always_comb begin
    pos_c      = done_q ? '0 : CW'(write_pos_q);
    sp_c       = CW'(size_pos_q);
    recent_new = {(done_q ? 32'd0 : recent_q[31:0]), data_byte_i};
    in_range   = pos_c < MAX_C;
    is_digit   = (data_byte_i >= CHAR_ZERO) && (data_byte_i <= CHAR_NINE);

    write_pos_d = write_pos_q;
    recent_d    = recent_q;
    marker_d    = marker_q;
    size_d      = size_q;
    size_pos_d  = size_pos_q;
    length_d    = length_q;
    done_d      = done_q;
    stopped_d   = stopped_q;

    if (load_i) begin
      if (done_q) begin
        write_pos_d = '0;
        recent_d    = '0;
        marker_d    = 1'b0;
        size_d      = 1'b0;
        size_pos_d  = '0;
        length_d    = '0;
        done_d      = 1'b0;
        stopped_d   = 1'b0;
      end
      if (in_range) begin
        recent_d    = recent_new;
        write_pos_d = PW'(pos_c + CW'(1));
        if (!marker_d && (pos_c >= CW'(4)) &&
            ((pos_c - CW'(4)) < CW'(marker_window_i)) && (recent_new == MARK_STONE)) begin
          marker_d = 1'b1;
        end
        if (size_d && !stopped_d && (pos_c >= sp_c + CW'(SIZE_TAG_BYTES)) &&
            (pos_c < sp_c + CW'(SIZE_TAG_BYTES + DIGIT_COUNT))) begin
          if (is_digit) begin
            length_d = (length_q << 3) + (length_q << 1) + LEN_W'(data_byte_i[3:0]);
          end else begin
            stopped_d = 1'b1;
          end
        end
        if (!size_d && (pos_c >= CW'(4)) && (recent_new[31:0] == MARK_SIZE)) begin
          size_d     = 1'b1;
          size_pos_d = PW'(pos_c - CW'(3));
        end
      end
      if (eop_i) begin
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      write_pos_q <= '0;
      recent_q    <= '0;
      marker_q    <= 1'b0;
      size_q      <= 1'b0;
      size_pos_q  <= '0;
      length_q    <= '0;
      done_q      <= 1'b0;
      stopped_q   <= 1'b0;
    end else begin
      write_pos_q <= write_pos_d;
      recent_q    <= recent_d;
      marker_q    <= marker_d;
      size_q      <= size_d;
      size_pos_q  <= size_pos_d;
      length_q    <= length_d;
      done_q      <= done_d;
      stopped_q   <= stopped_d;
    end
  end

  assign flags_o.packet_done = done_q;
  assign flags_o.marker_seen = marker_q;
  assign flags_o.size_seen   = size_q;
  assign size_pos_o          = size_pos_q;
  assign length_o            = length_q;
  assign write_pos_o         = write_pos_q;
  assign we_o                = load_i && in_range;
  assign waddr_o             = pos_c[AW-1:0];

endmodule

// ===== rtl/marker_length_payload_extractor_unit.sv =====
// ----------------------------------------------------------------------------
// marker_length_payload_extractor_unit
// Packet byte loader with marker/length scan and payload read-out.
// ----------------------------------------------------------------------------
// One item is taken in every clock cycle; busy stays low. A load item writes
// its byte into the packet RAM and updates the scan in the same cycle and
// gives no result. A read taken once the packet has ended gives its result
// in the next cycle, from the registered read port of the packet RAM; other
// reads give none. The result is shown for a single cycle under result_valid_o,
// with no way for the receiver to hold it. The marker window register may be
// written whenever cfg_ready_o is high, which is always.
module marker_length_payload_extractor_unit import mlpe_pkg::*; #(
  parameter int unsigned MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic             kind_i,
  input  logic [7:0]       data_byte_i,
  input  logic             end_of_packet_i,
  output logic             result_valid_o,
  output logic [7:0]       payload_byte_o,
  output logic             byte_valid_o,
  output logic             payload_last_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [WIN_W-1:0] cfg_data_i
);

  localparam int unsigned PW = $clog2(MAX_PACKET_BYTES + 1);
  localparam int unsigned AW = $clog2(MAX_PACKET_BYTES);
  localparam int unsigned CW = ((PW > LEN_W) ? PW : LEN_W) + 2;
  localparam logic [CW-1:0] MAX_C = CW'(MAX_PACKET_BYTES);

  logic             accept;
  logic             load;
  logic             rd;
  scan_flags_t      flags;
  logic [PW-1:0]    size_pos;
  logic [LEN_W-1:0] length;
  logic [PW-1:0]    write_pos;
  logic             we;
  logic [AW-1:0]    waddr;
  logic [7:0]       rdata;

  logic [WIN_W-1:0] window_q;
  logic [CW-1:0]    rp_q, rp_d;
  logic             res_valid_q, res_valid_d;
  logic             bvalid_q, bvalid_d;
  logic             last_q, last_d;

  logic [CW-1:0]    start_c, end_raw, end_c, rp_eff;
  logic             has_payload, hit;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;
  assign load        = accept && (kind_i == KIND_LOAD);
  assign rd          = accept && (kind_i == KIND_READ);

  mlpe_scan #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_scan (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (load),
    .data_byte_i     (data_byte_i),
    .eop_i           (end_of_packet_i),
    .marker_window_i (window_q),
    .flags_o         (flags),
    .size_pos_o      (size_pos),
    .length_o        (length),
    .write_pos_o     (write_pos),
    .we_o            (we),
    .waddr_o         (waddr)
  );

  // Payload window, clamped to the stored packet.
  always_comb begin
    start_c     = CW'(size_pos) + CW'(PAYLOAD_OFFSET);
    end_raw     = start_c + CW'(length);
    end_c       = (end_raw > CW'(write_pos)) ? CW'(write_pos) : end_raw;
    rp_eff      = (rp_q < start_c) ? start_c : rp_q;
    has_payload = flags.marker_seen && flags.size_seen && (length != '0);
    hit         = has_payload && (rp_eff < end_c) && (rp_eff < MAX_C);

    rp_d        = rp_q;
    res_valid_d = 1'b0;
    bvalid_d    = 1'b0;
    last_d      = 1'b1;

    if (load && flags.packet_done) begin
      rp_d = '0;
    end
    if (rd && flags.packet_done) begin
      res_valid_d = 1'b1;
      if (has_payload) begin
        rp_d = rp_eff;
      end
      if (hit) begin
        rp_d     = rp_eff + CW'(1);
        bvalid_d = 1'b1;
        last_d   = (rp_eff + CW'(1)) >= end_c;
      end
    end
  end

  mlpe_ram #(
    .WIDTH (8),
    .DEPTH (MAX_PACKET_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (data_byte_i),
    .re_i    (hit && rd && flags.packet_done),
    .raddr_i (rp_eff[AW-1:0]),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q    <= MARKER_WINDOW_RESET;
      rp_q        <= '0;
      res_valid_q <= 1'b0;
      bvalid_q    <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        window_q <= cfg_data_i;
      end
      rp_q        <= rp_d;
      res_valid_q <= res_valid_d;
      bvalid_q    <= bvalid_d;
      last_q      <= last_d;
    end
  end

  assign result_valid_o = res_valid_q;
  assign byte_valid_o   = bvalid_q;
  assign payload_last_o = last_q;
  assign payload_byte_o = bvalid_q ? rdata : 8'd0;

endmodule

// ===== rtl/mlpe_checker.sv =====
// ----------------------------------------------------------------------------
// mlpe_checker
// Port-level checks of the payload extractor, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mlpe_checker import mlpe_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       kind_i,
  input logic       result_valid_o,
  input logic [7:0] payload_byte_o,
  input logic       byte_valid_o,
  input logic       payload_last_o
);

  logic rd_taken;
  logic ld_taken;
  logic no_byte;
  logic empty_ok;

  assign rd_taken = start && !busy && (kind_i == KIND_READ);
  assign ld_taken = start && !busy && (kind_i == KIND_LOAD);
  assign no_byte  = result_valid_o && !byte_valid_o;
  assign empty_ok = payload_last_o && (payload_byte_o == 8'd0);

  // A result always answers a read item taken in the cycle before.
  `ASSERT_IMPL(a_result_follows_read, clk_i, rst_ni, result_valid_o, $past(rd_taken))

  // A load item never produces a result.
  `ASSERT_NEXT(a_load_no_result, clk_i, rst_ni, ld_taken, !result_valid_o)

  // Empty results carry a zero byte and the last mark.
  `ASSERT_IMPL(a_empty_result, clk_i, rst_ni, no_byte, empty_ok)

  // A payload byte is only flagged on a result cycle.
  `ASSERT_IMPL(a_valid_in_result, clk_i, rst_ni, byte_valid_o, result_valid_o)

endmodule

bind marker_length_payload_extractor_unit mlpe_checker u_mlpe_checker (.*);

// ===== tb/marker_length_payload_extractor_unit_tb.sv =====
// ----------------------------------------------------------------------------
// marker_length_payload_extractor_unit_tb
// Drives packets into the extractor and reads the payload back. A class-based
// scoreboard mirrors the marker and length scan item by item and checks each
// returned byte. Packets are mostly well formed with random content, plus
// noise packets, broken markers and lengths, early reads and random gaps.
// The marker window is reprogrammed between phases, the extremes among them.
// ----------------------------------------------------------------------------
module marker_length_payload_extractor_unit_tb;
  import mlpe_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned PHASE_ITEMS   = 125;

  typedef struct {
    logic [7:0] data;
    logic       valid;
    logic       last;
  } payload_t;

  // Mirror of the scan state; computes the byte each read must return.
  class payload_scoreboard;
    logic [7:0]       store [MAX_PACKET_BYTES_DEF];
    int unsigned      wr_pos;
    int unsigned      size_pos;
    int unsigned      rd_pos;
    logic [39:0]      recent;
    logic [LEN_W-1:0] length;
    bit               marker_seen;
    bit               size_seen;
    bit               done;
    bit               digits_stopped;
    logic [WIN_W-1:0] window;
    payload_t         expected_payload[$];
    int               errors;

    function new();
      window = MARKER_WINDOW_RESET;
      errors = 0;
      clear();
    endfunction

    function void clear();
      wr_pos         = 0;
      size_pos       = 0;
      rd_pos         = 0;
      recent         = '0;
      length         = '0;
      marker_seen    = 1'b0;
      size_seen      = 1'b0;
      done           = 1'b0;
      digits_stopped = 1'b0;
    endfunction

    function void note_item(logic k, logic [7:0] b, logic e);
      payload_t    want;
      int unsigned pos;
      int unsigned pay_start;
      int unsigned pay_end;
      if (k == KIND_READ) begin
        // no result until the packet has ended
        if (!done) return;
        want = '{8'h00, 1'b0, 1'b1};
        if (marker_seen && size_seen && length != 0) begin
          pay_start = size_pos + PAYLOAD_OFFSET;
          pay_end   = pay_start + length;
          if (pay_end > wr_pos) pay_end = wr_pos;
          if (rd_pos < pay_start) rd_pos = pay_start;
          if (rd_pos < pay_end && rd_pos < MAX_PACKET_BYTES_DEF) begin
            want.data  = store[rd_pos];
            want.valid = 1'b1;
            want.last  = (rd_pos + 1 >= pay_end);
            rd_pos++;
          end
        end
        expected_payload.push_back(want);
        return;
      end
      if (done) clear();
      pos = wr_pos;
      // drop bytes past capacity, but still honor their end flag
      if (pos < MAX_PACKET_BYTES_DEF) begin
        store[pos] = b;
        recent     = {recent[31:0], b};
        if (!marker_seen && pos >= 4 && (pos - 4) < window && recent == MARK_STONE)
          marker_seen = 1'b1;
        if (size_seen && !digits_stopped && pos >= size_pos + SIZE_TAG_BYTES &&
            pos < size_pos + SIZE_TAG_BYTES + DIGIT_COUNT) begin
          if (b >= CHAR_ZERO && b <= CHAR_NINE)
            length = LEN_W'(length * 10 + (b - CHAR_ZERO));
          else
            digits_stopped = 1'b1;
        end
        if (!size_seen && pos >= 4 && recent[31:0] == MARK_SIZE) begin
          size_seen = 1'b1;
          size_pos  = pos - 3;
        end
        wr_pos = pos + 1;
      end
      if (e) done = 1'b1;
    endfunction

    function void check_result(logic [7:0] b, logic v, logic l);
      payload_t want;
      if (expected_payload.size() == 0) begin
        errors++;
        $display("%0t: result with none expected: byte=%h valid=%b last=%b",
                 $time, b, v, l);
        return;
      end
      want = expected_payload.pop_front();
      if (b !== want.data) begin
        errors++;
        $display("%0t: payload_byte expected %h actual %h", $time, want.data, b);
      end
      if (v !== want.valid) begin
        errors++;
        $display("%0t: byte_valid expected %b actual %b", $time, want.valid, v);
      end
      if (l !== want.last) begin
        errors++;
        $display("%0t: payload_last expected %b actual %b", $time, want.last, l);
      end
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni          = 1'b0;
  logic             start           = 1'b0;
  logic             busy;
  logic             kind_i          = KIND_LOAD;
  logic [7:0]       data_byte_i     = 8'h00;
  logic             end_of_packet_i = 1'b0;
  logic             result_valid_o;
  logic [7:0]       payload_byte_o;
  logic             byte_valid_o;
  logic             payload_last_o;
  logic             cfg_valid_i     = 1'b0;
  logic             cfg_ready_o;
  logic [WIN_W-1:0] cfg_data_i      = '0;

  payload_scoreboard sb;
  logic [7:0]        pkt_bytes[$];
  bit                noisy;
  int                phase_items;
  int unsigned       cycle_count = 0;

  marker_length_payload_extractor_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .kind_i          (kind_i),
    .data_byte_i     (data_byte_i),
    .end_of_packet_i (end_of_packet_i),
    .result_valid_o  (result_valid_o),
    .payload_byte_o  (payload_byte_o),
    .byte_valid_o    (byte_valid_o),
    .payload_last_o  (payload_last_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[marker_length_payload_extractor_unit] ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && sb != null && result_valid_o === 1'b1)
      sb.check_result(payload_byte_o, byte_valid_o, payload_last_o);
  end

  task automatic send_item(input logic k, input logic [7:0] b, input logic e,
                           input int gap);
    repeat (gap) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
    @(negedge clk_i);
    start           <= 1'b1;
    kind_i          <= k;
    data_byte_i     <= b;
    end_of_packet_i <= e;
    do @(posedge clk_i); while (busy !== 1'b0);
    sb.note_item(k, b, e);
    phase_items++;
  endtask

  // Hold off until every read has answered and the pipeline is quiet.
  task automatic drain();
    @(negedge clk_i);
    start <= 1'b0;
    while (sb.expected_payload.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_window(input logic [WIN_W-1:0] w);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= w;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    sb.window = w;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) pkt_bytes.push_back(s[i]);
  endfunction

  function automatic void push_random(input int n);
    for (int i = 0; i < n; i++) pkt_bytes.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic int draw_gap(input bit burst);
    return burst ? 0 : $urandom_range(0, 18);
  endfunction

  // Build one packet into pkt_bytes; return how many reads to issue after it.
  function automatic int build_packet();
    int    stone_at;
    int    len_val;
    int    tail;
    int    reads;
    int    w;
    bit    size_first;
    string marker;
    string digits;
    string size_field;
    pkt_bytes.delete();
    noisy = 1'b0;
    w     = int'(sb.window);
    if ($urandom_range(0, 9) == 0) begin
      noisy = 1'b1;
      push_random($urandom_range(1, 12));
      return $urandom_range(0, 3);
    end
    // straddle the window edge when that stays cheap
    if (w <= 40 && $urandom_range(0, 2) == 0) stone_at = w - 2 + $urandom_range(0, 3);
    else stone_at = $urandom_range(0, 8);
    if (stone_at < 0) stone_at = 0;
    case ($urandom_range(0, 9))
      0:       marker = "";
      1:       marker = "stine";
      default: marker = "stone";
    endcase
    case ($urandom_range(0, 5))
      0:       len_val = 0;
      1:       len_val = $urandom_range(0, 99999);
      default: len_val = $urandom_range(1, 24);
    endcase
    digits = $sformatf("%0d", len_val);
    while (digits.len() < 5 && $urandom_range(0, 2) == 0) digits = {"0", digits};
    if ($urandom_range(0, 7) == 0) digits = {digits, "7"};
    if ($urandom_range(0, 11) == 0) digits = {"-", digits};
    size_field = ($urandom_range(0, 11) == 0) ? {"sizE", digits} : {"size", digits};
    if (digits.len() < 5) begin
      case ($urandom_range(0, 3))
        0:       size_field = {size_field, " "};
        1:       size_field = {size_field, "+"};
        2:       size_field = {size_field, "-"};
        default: size_field = {size_field, "x"};
      endcase
    end
    while (size_field.len() < 9) size_field = {size_field, "."};
    tail = (len_val <= 40) ? len_val : $urandom_range(0, 30);
    tail = tail + $urandom_range(0, 4) - 2;
    if (tail < 0) tail = 0;
    size_first = ($urandom_range(0, 4) == 0);
    if (size_first) begin
      // a size tag at position 0 is not seen; a second one may follow
      push_random($urandom_range(0, 1));
      push_text(size_field);
      push_random(tail);
      push_text(marker);
      if ($urandom_range(0, 1) == 0) begin
        push_text(size_field);
        push_random(tail);
      end
    end else begin
      push_random(stone_at);
      push_text(marker);
      push_random($urandom_range(0, 3));
      push_text(size_field);
      push_random(tail);
    end
    reads = ((len_val < tail) ? len_val : tail) + $urandom_range(0, 3);
    if ($urandom_range(0, 7) == 0) reads = $urandom_range(0, reads);
    return reads;
  endfunction

  task automatic run_packet(input int reads);
    bit burst;
    burst = ($urandom_range(0, 3) == 0);
    foreach (pkt_bytes[i]) begin
      if ($urandom_range(0, 19) == 0)
        send_item(KIND_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  draw_gap(burst));
      send_item(KIND_LOAD, pkt_bytes[i],
                (i == pkt_bytes.size() - 1) || (noisy && $urandom_range(0, 3) == 0),
                draw_gap(burst));
    end
    repeat (reads)
      send_item(KIND_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                draw_gap(burst));
  endtask

  initial begin
    int windows[6];
    sb = new();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // read before any packet, then a short packet: one-digit length stopped
    // by a sign, payload holding both byte extremes, one read past the end
    send_item(KIND_READ, 8'hFF, 1'b1, 0);
    pkt_bytes.delete();
    push_text("stonesize2+...");
    pkt_bytes.push_back(8'h00);
    pkt_bytes.push_back(8'hFF);
    noisy = 1'b0;
    foreach (pkt_bytes[i]) send_item(KIND_LOAD, pkt_bytes[i], i == pkt_bytes.size() - 1, 0);
    repeat (3) send_item(KIND_READ, 8'h00, 1'b0, $urandom_range(0, 2));
    drain();

    windows = '{1, 0, 1024, $urandom_range(1, 40), $urandom_range(1, 1024),
                int'(MARKER_WINDOW_RESET)};
    foreach (windows[p]) begin
      write_window(WIN_W'(windows[p]));
      phase_items = 0;
      if (windows[p] == 1024) begin
        // overlong packet: payload clamped at capacity, excess bytes dropped
        pkt_bytes.delete();
        push_random(995);
        push_text("size00040stone");
        push_random(21);
        noisy = 1'b0;
        foreach (pkt_bytes[i])
          send_item(KIND_LOAD, pkt_bytes[i], i == pkt_bytes.size() - 1, 0);
        repeat (25) send_item(KIND_READ, 8'($urandom_range(0, 255)), 1'b0, 0);
        phase_items = 0;
      end
      while (phase_items < PHASE_ITEMS) run_packet(build_packet());
      drain();
    end

    if (sb.errors == 0)
      $display("[marker_length_payload_extractor_unit] OK");
    else
      $display("[marker_length_payload_extractor_unit] ERROR");
    $finish;
  end

endmodule
